### design/i2da_pkg.sv
`timescale 1ns / 1ps
package i2da_pkg;

  // width of the signed input value
  localparam int VALUE_BITS = 32;
  // input stream data width, padded to whole bytes
  localparam int IN_TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
  // decimal digits needed for a magnitude of up to 2^(VALUE_BITS-1)
  localparam int NUM_DIGITS = (VALUE_BITS * 302) / 1000 + 1;
  localparam int BCD_BITS = 4 * NUM_DIGITS;
  localparam int STEP_W = $clog2(VALUE_BITS + 1);
  localparam int DIG_W = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
  localparam logic [3:0] BCD_ADJ_ADD   = 4'd3;

  // classified item passed from front to back
  typedef struct packed {
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
  } i2da_entry_t;

endpackage

### design/int_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
// Flow: an input beat is registered in the front stage, queued, and the back end
//   runs the one-bit-per-cycle shift-add-3 loop, skips leading zeros one digit per
//   cycle and emits sign and digits one character per cycle unless the output stalls; it takes
//   no new number until the last is emitted, and a 2-entry queue lets inputs keep arriving.
// Reset: rst_ni is asynchronous active low and empties the front stage, queue and output.
module int_to_decimal_ascii_unit
  import i2da_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_TDATA_BITS-1:0] s_axis_tdata,   // [VALUE_BITS-1:0] value
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [7:0]               m_axis_tdata,   // [7:0] character
  output logic                     m_axis_tlast
);

  logic        f_valid, f_ready;
  i2da_entry_t f_entry;
  logic        q_valid, q_ready;
  i2da_entry_t q_entry;

  // sign and magnitude stage
  i2da_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_value_i  (s_axis_tdata[VALUE_BITS-1:0]),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_entry_o (f_entry)
  );

  // decoupling queue
  i2da_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_entry_i (f_entry),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_entry_o  (q_entry)
  );

  // binary to bcd and character emit
  i2da_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_entry_i  (q_entry),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

### design/i2da_front.sv
`timescale 1ns / 1ps
module i2da_front
  import i2da_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] in_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output i2da_entry_t           out_entry_o
);

  logic        valid_q, valid_d;
  i2da_entry_t entry_q, entry_d;

  assign in_ready_o = !valid_q || out_ready_i;

  // split into sign and unsigned magnitude
  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      valid_d     = 1'b1;
      entry_d.neg = in_value_i[VALUE_BITS-1];
      entry_d.mag = in_value_i[VALUE_BITS-1] ? (~in_value_i + VALUE_BITS'(1)) : in_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign out_valid_o = valid_q;
  assign out_entry_o = entry_q;

endmodule

### design/i2da_fifo.sv
`timescale 1ns / 1ps
module i2da_fifo
  import i2da_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  output logic        push_ready_o,
  input  i2da_entry_t push_entry_i,
  output logic        pop_valid_o,
  input  logic        pop_ready_i,
  output i2da_entry_t pop_entry_o
);

  i2da_entry_t mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_entry_o = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_entry_i;
  end

endmodule

### design/i2da_back.sv
`timescale 1ns / 1ps
module i2da_back
  import i2da_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  i2da_entry_t in_entry_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_char_o,
  output logic        out_last_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIG
  } state_e;

  state_e                state_q;
  logic                  neg_q;
  logic [VALUE_BITS-1:0] bin_q;
  logic [BCD_BITS-1:0]   bcd_q;
  logic [STEP_W-1:0]     step_cnt_q;
  logic [DIG_W-1:0]      dig_cnt_q;
  logic                  out_valid_q;
  logic [7:0]            out_char_q;
  logic                  out_last_q;

  logic [BCD_BITS-1:0] bcd_adj;
  logic [3:0]          top_digit;
  logic                out_free;
  logic                emit;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= BCD_ADJ_LIMIT) ?
                          (bcd_q[4*i +: 4] + BCD_ADJ_ADD) : bcd_q[4*i +: 4];
    end
  end

  assign top_digit  = bcd_q[BCD_BITS-1 -: 4];
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  // a character is loaded into the output register this cycle
  assign emit       = (state_q == ST_SIGN || state_q == ST_DIG) && out_free;

  // conversion sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      neg_q       <= 1'b0;
      bin_q       <= '0;
      bcd_q       <= '0;
      step_cnt_q  <= '0;
      dig_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !emit) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            neg_q      <= in_entry_i.neg;
            bin_q      <= in_entry_i.mag;
            bcd_q      <= '0;
            step_cnt_q <= STEP_W'(VALUE_BITS);
            dig_cnt_q  <= DIG_W'(NUM_DIGITS);
            state_q    <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd_q      <= {bcd_adj[BCD_BITS-2:0], bin_q[VALUE_BITS-1]};
          bin_q      <= {bin_q[VALUE_BITS-2:0], 1'b0};
          step_cnt_q <= step_cnt_q - STEP_W'(1);
          if (step_cnt_q == STEP_W'(1)) state_q <= ST_SKIP;
        end
        ST_SKIP: begin
          // drop leading zeros, keep at least one digit
          if (top_digit == 4'd0 && dig_cnt_q != DIG_W'(1)) begin
            bcd_q     <= {bcd_q[BCD_BITS-5:0], 4'd0};
            dig_cnt_q <= dig_cnt_q - DIG_W'(1);
          end else begin
            state_q <= neg_q ? ST_SIGN : ST_DIG;
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_char_q  <= CH_MINUS;
            out_last_q  <= 1'b0;
            state_q     <= ST_DIG;
          end
        end
        ST_DIG: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_char_q  <= CH_ZERO + {4'd0, top_digit};
            out_last_q  <= (dig_cnt_q == DIG_W'(1));
            bcd_q       <= {bcd_q[BCD_BITS-5:0], 4'd0};
            dig_cnt_q   <= dig_cnt_q - DIG_W'(1);
            if (dig_cnt_q == DIG_W'(1)) state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  // digit counter never runs out while digits are emitted
  a_dig_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIG) |-> (dig_cnt_q != '0))
    else $error("digit count empty while emitting");

  // every digit reaching the output is a valid decimal digit
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIG && out_free) |-> (top_digit <= 4'd9))
    else $error("bcd digit out of range");

  // the sign is never the final character
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_char_q == CH_MINUS) |-> !out_last_q)
    else $error("minus sign flagged as last");

  // the final digit of a number carries last and the sequencer returns to idle
  a_start_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIG && out_free && dig_cnt_q == DIG_W'(1)) |=>
      (out_valid_q && out_last_q && state_q == ST_IDLE))
    else $error("number ended without last flag");

endmodule
